>>> rtl/stt_pkg.sv
`default_nettype none

package stt_pkg;

   localparam int MAX_NONZERO = 64;
   localparam int MAX_COLS    = 64;
   localparam int ROW_WIDTH   = 16;
   localparam int COL_WIDTH   = 7;
   localparam int VALUE_WIDTH = 32;
   localparam int CNT_WIDTH   = $clog2(MAX_NONZERO + 1);
   localparam logic [COL_WIDTH-1:0] COL_COUNT_RESET = COL_WIDTH'(MAX_COLS);

   typedef struct packed {
      logic [COL_WIDTH-1:0]          col;
      logic [ROW_WIDTH-1:0]          row;
      logic signed [VALUE_WIDTH-1:0] value;
   } entry_type;

   // command broadcast to every cell
   typedef struct packed {
      logic insert;
      logic shift_out;
   } cell_cmd_type;

   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } state_type;

endpackage

`default_nettype wire

>>> rtl/stt_cell.sv
`default_nettype none

module stt_cell (
   input  wire                  clock,
   input  wire                  reset,
   input  stt_pkg::cell_cmd_type cmd,
   input  stt_pkg::entry_type   new_entry,
   input  wire                  left_keep,
   input  stt_pkg::entry_type   left_entry,
   input  wire                  left_valid,
   input  stt_pkg::entry_type   right_entry,
   input  wire                  right_valid,
   output stt_pkg::entry_type   entry_q,
   output logic                 valid_q,
   output logic                 keep
);

   stt_pkg::entry_type entry_ff, entry_in;
   logic               valid_ff, valid_in;

   // an entry stays put when the new one sorts after it (ties keep arrival order)
   assign keep = valid_ff && (entry_ff.col <= new_entry.col);

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (cmd.insert) begin
         if (!keep) begin
            if (left_keep) begin
               entry_in = new_entry;
               valid_in = 1'b1;
            end else begin
               entry_in = left_entry;
               valid_in = left_valid;
            end
         end
      end else if (cmd.shift_out) begin
         entry_in = right_entry;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_q = entry_ff;
   assign valid_q = valid_ff;

endmodule

`default_nettype wire

>>> rtl/stt_ctrl.sv
`default_nettype none

module stt_ctrl (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               start,
   input  wire                               last_entry,
   output logic                              busy,
   output stt_pkg::cell_cmd_type             cmd,
   output logic                              rsp_valid,
   output logic                              rsp_last,
   output logic [stt_pkg::CNT_WIDTH-1:0]     count
);

   stt_pkg::state_type state_ff, state_in;
   logic [stt_pkg::CNT_WIDTH-1:0] count_ff, count_in;
   logic accept;
   logic full;

   assign accept = start && (state_ff == stt_pkg::ST_LOAD);
   assign full   = (count_ff == stt_pkg::CNT_WIDTH'(stt_pkg::MAX_NONZERO));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         stt_pkg::ST_LOAD: begin
            if (accept && last_entry) state_in = stt_pkg::ST_DRAIN;
         end
         stt_pkg::ST_DRAIN: begin
            if (count_ff <= stt_pkg::CNT_WIDTH'(1)) state_in = stt_pkg::ST_LOAD;
         end
         default: state_in = stt_pkg::ST_LOAD;
      endcase
   end

   always_comb begin
      cmd.insert    = 1'b0;
      cmd.shift_out = 1'b0;
      busy          = 1'b0;
      rsp_valid     = 1'b0;
      count_in      = count_ff;
      unique case (state_ff)
         stt_pkg::ST_LOAD: begin
            // a full store drops the beat but still honors its last flag
            if (accept && !full) begin
               cmd.insert = 1'b1;
               count_in   = count_ff + stt_pkg::CNT_WIDTH'(1);
            end
         end
         stt_pkg::ST_DRAIN: begin
            busy = 1'b1;
            if (count_ff != '0) begin
               cmd.shift_out = 1'b1;
               rsp_valid     = 1'b1;
               count_in      = count_ff - stt_pkg::CNT_WIDTH'(1);
            end
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   assign rsp_last = (count_ff == stt_pkg::CNT_WIDTH'(1));
   assign count    = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stt_pkg::ST_LOAD;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/sparse_triplet_transpose.sv
`default_nettype none

// sparse matrix transpose over (row, column, value) triplets
// req channel: one triplet is taken at each clock edge with start high and busy
// low; req_last_entry marks the final triplet of a matrix. the entry is placed
// straight into column order by a row of 64 cells that shift to make room (ties
// keep arrival order)
// rsp channel: the cycle after the last beat, busy rises and the cells shift out
// through cell 0, one transposed beat per cycle, rsp_valid high for exactly one
// cycle per beat; rsp_last_result flags the final one. the receiver cannot stall
// the drain rate is set by the single output at cell 0
// entries beyond 64 are dropped; column 0 is raised to 1 and a column above
// col_count (read as 1 when 0 and as 64 when above 64) is clamped to it
// csr channel: csr_col_count is written at csr_valid and csr_ready; it is
// always ready and is meant to be written only while idle
// reset empties the cells and sets col_count to 64
module sparse_triplet_transpose (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      start,
   output logic                                     busy,
   input  wire  [stt_pkg::ROW_WIDTH-1:0]            req_src_row,
   input  wire  [stt_pkg::COL_WIDTH-1:0]            req_src_col,
   input  wire  signed [stt_pkg::VALUE_WIDTH-1:0]   req_entry_value,
   input  wire                                      req_last_entry,
   output logic                                     rsp_valid,
   output logic [stt_pkg::COL_WIDTH-1:0]            rsp_out_row,
   output logic [stt_pkg::ROW_WIDTH-1:0]            rsp_out_col,
   output logic signed [stt_pkg::VALUE_WIDTH-1:0]   rsp_out_value,
   output logic                                     rsp_last_result,
   input  wire                                      csr_valid,
   output logic                                     csr_ready,
   input  wire  [stt_pkg::COL_WIDTH-1:0]            csr_col_count
);

   localparam int N = stt_pkg::MAX_NONZERO;

   logic [stt_pkg::COL_WIDTH-1:0] col_count_ff, col_count_in;
   logic [stt_pkg::COL_WIDTH-1:0] col_limit;
   logic [stt_pkg::COL_WIDTH-1:0] col_clamped;
   stt_pkg::entry_type            new_entry;
   stt_pkg::cell_cmd_type         cmd;
   logic                          rsp_last;
   logic [stt_pkg::CNT_WIDTH-1:0] count;

   stt_pkg::entry_type cell_entry [N];
   logic [N-1:0]       cell_valid;
   logic [N-1:0]       cell_keep;

   assign csr_ready = 1'b1;

   always_comb begin
      col_count_in = col_count_ff;
      if (csr_valid && csr_ready) col_count_in = csr_col_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= stt_pkg::COL_COUNT_RESET;
      end else begin
         col_count_ff <= col_count_in;
      end
   end

   always_comb begin
      priority if (col_count_ff == '0) begin
         col_limit = stt_pkg::COL_WIDTH'(1);
      end else if (col_count_ff > stt_pkg::COL_WIDTH'(stt_pkg::MAX_COLS)) begin
         col_limit = stt_pkg::COL_WIDTH'(stt_pkg::MAX_COLS);
      end else begin
         col_limit = col_count_ff;
      end
   end

   always_comb begin
      priority if (req_src_col == '0) begin
         col_clamped = stt_pkg::COL_WIDTH'(1);
      end else if (req_src_col > col_limit) begin
         col_clamped = col_limit;
      end else begin
         col_clamped = req_src_col;
      end
   end

   assign new_entry.col   = col_clamped;
   assign new_entry.row   = req_src_row;
   assign new_entry.value = req_entry_value;

   stt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .last_entry (req_last_entry),
      .busy       (busy),
      .cmd        (cmd),
      .rsp_valid  (rsp_valid),
      .rsp_last   (rsp_last),
      .count      (count)
   );

   for (genvar i = 0; i < N; i++) begin : g_cell
      stt_pkg::entry_type left_entry, right_entry;
      logic               left_keep, left_valid, right_valid;

      if (i == 0) begin : g_head
         assign left_keep  = 1'b1;
         assign left_entry = new_entry;
         assign left_valid = 1'b0;
      end else begin : g_body
         assign left_keep  = cell_keep[i-1];
         assign left_entry = cell_entry[i-1];
         assign left_valid = cell_valid[i-1];
      end

      if (i == N - 1) begin : g_tail
         assign right_entry = new_entry;
         assign right_valid = 1'b0;
      end else begin : g_next
         assign right_entry = cell_entry[i+1];
         assign right_valid = cell_valid[i+1];
      end

      stt_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .new_entry   (new_entry),
         .left_keep   (left_keep),
         .left_entry  (left_entry),
         .left_valid  (left_valid),
         .right_entry (right_entry),
         .right_valid (right_valid),
         .entry_q     (cell_entry[i]),
         .valid_q     (cell_valid[i]),
         .keep        (cell_keep[i])
      );
   end

   assign rsp_out_row     = cell_entry[0].col;
   assign rsp_out_col     = cell_entry[0].row;
   assign rsp_out_value   = cell_entry[0].value;
   assign rsp_last_result = rsp_last;

   // the cells hold exactly as many entries as the control has counted
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == 32'(count))
      else $error("cell occupancy disagrees with entry count");

   a_valid_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy && cell_valid[0])
      else $error("result beat outside of drain");

   a_last_ends_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_result |=> !busy && (cell_valid == '0))
      else $error("drain did not end after last beat");

   a_last_starts_drain: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_last_entry |=> busy && rsp_valid)
      else $error("last entry did not start the drain");

endmodule

`default_nettype wire
